// ===== src/pointer_cursor_region_select_assert.svh =====
// ----------------------------------------------------------------------------
// Pointer cursor region select assertion macros
// Concurrent check macros, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef POINTER_CURSOR_REGION_SELECT_ASSERT_SVH
`define POINTER_CURSOR_REGION_SELECT_ASSERT_SVH

`ifndef SYNTHESIS

`define PCRS_ASSERT_NOW(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("pcrs check failed");

`define PCRS_ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("pcrs check failed");

`else

`define PCRS_ASSERT_NOW(lbl, ant, con)

`define PCRS_ASSERT_NEXT(lbl, ant, con)

`endif

`endif

// ===== src/pcrs_pkg.sv =====
// ----------------------------------------------------------------------------
// Pointer cursor region select package
// Types, screen and image geometry and the cursor scaling functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcrs_pkg;

  localparam int SCREEN_W = 640;
  localparam int SCREEN_H = 480;
  localparam int IMAGE_W  = 160;
  localparam int IMAGE_H  = 120;

  localparam int SX_W  = 10;
  localparam int SY_W  = 9;
  localparam int IX_W  = 8;
  localparam int IY_W  = 7;
  localparam int VAL_W = 16;

  // Scaling by a fixed-point reciprocal; the rounding up keeps the quotient exact.
  localparam int SCALE_SHIFT = 26;
  localparam longint MUL_X = ((64'(IMAGE_W) << SCALE_SHIFT) + SCREEN_W - 1) / SCREEN_W;
  localparam longint MUL_Y = ((64'(IMAGE_H) << SCALE_SHIFT) + SCREEN_H - 1) / SCREEN_H;
  localparam int MULX_W = $clog2(MUL_X + 1);
  localparam int MULY_W = $clog2(MUL_Y + 1);
  localparam int PX_W = SX_W + MULX_W;
  localparam int PY_W = SY_W + MULY_W;

  typedef enum logic [1:0] {
    KIND_MOVE_X = 2'd0,
    KIND_MOVE_Y = 2'd1,
    KIND_LEFT   = 2'd2,
    KIND_RIGHT  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                    kind;
    logic signed [VAL_W-1:0]  value;
  } in_evt_t;

  typedef struct packed {
    logic [SX_W-1:0] screen_x;
    logic [SY_W-1:0] screen_y;
    logic [IX_W-1:0] image_x;
    logic [IY_W-1:0] image_y;
    logic            left_down;
    logic            right_down;
    logic [IX_W-1:0] start_x;
    logic [IY_W-1:0] start_y;
    logic [IX_W-1:0] end_x;
    logic [IY_W-1:0] end_y;
    logic            region_valid;
    logic            dragging;
  } out_res_t;

  typedef struct packed {
    logic [SX_W-1:0] pos_x;
    logic [SY_W-1:0] pos_y;
    logic            left_level;
    logic            right_level;
    logic [IX_W-1:0] start_x;
    logic [IY_W-1:0] start_y;
    logic [IX_W-1:0] end_x;
    logic [IY_W-1:0] end_y;
    logic            active;
    logic            dragging;
  } state_t;

  function automatic logic [IX_W-1:0] scale_x(input logic [SX_W-1:0] p);
    logic [PX_W-1:0] prod;
    logic [PX_W-1:0] q;
    prod = PX_W'(p) * PX_W'(MUL_X);
    q = prod >> SCALE_SHIFT;
    if (q > PX_W'(IMAGE_W - 1)) begin
      q = PX_W'(IMAGE_W - 1);
    end
    return q[IX_W-1:0];
  endfunction

  function automatic logic [IY_W-1:0] scale_y(input logic [SY_W-1:0] p);
    logic [PY_W-1:0] prod;
    logic [PY_W-1:0] q;
    prod = PY_W'(p) * PY_W'(MUL_Y);
    q = prod >> SCALE_SHIFT;
    if (q > PY_W'(IMAGE_H - 1)) begin
      q = PY_W'(IMAGE_H - 1);
    end
    return q[IY_W-1:0];
  endfunction

endpackage

// ===== src/pcrs_update.sv =====
// ----------------------------------------------------------------------------
// Pointer cursor region select state update
// Applies one event to the cursor, button levels and selection region.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcrs_update import pcrs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  logic    sel_mode,
  input  in_evt_t evt,
  output state_t  st
);

  localparam int SUM_W = 18;

  state_t st_r;
  state_t st_nxt;

  logic signed [SUM_W-1:0] delta;
  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_y;
  logic [SX_W-1:0]         clamp_x;
  logic [SY_W-1:0]         clamp_y;
  logic                    level;
  logic [IX_W-1:0]         cur_ix;
  logic [IY_W-1:0]         cur_iy;

  always_comb begin
    delta = $signed({{(SUM_W-VAL_W){evt.value[VAL_W-1]}}, evt.value});
    sum_x = $signed({{(SUM_W-SX_W){1'b0}}, st_r.pos_x}) + delta;
    sum_y = $signed({{(SUM_W-SY_W){1'b0}}, st_r.pos_y}) + delta;
    if (sum_x < 0) begin
      clamp_x = '0;
    end else if (sum_x > $signed(SUM_W'(SCREEN_W - 1))) begin
      clamp_x = SX_W'(SCREEN_W - 1);
    end else begin
      clamp_x = sum_x[SX_W-1:0];
    end
    if (sum_y < 0) begin
      clamp_y = '0;
    end else if (sum_y > $signed(SUM_W'(SCREEN_H - 1))) begin
      clamp_y = SY_W'(SCREEN_H - 1);
    end else begin
      clamp_y = sum_y[SY_W-1:0];
    end
  end

  assign level  = |evt.value;
  assign cur_ix = scale_x(st_r.pos_x);
  assign cur_iy = scale_y(st_r.pos_y);

  always_comb begin
    st_nxt = st_r;
    unique case (evt.kind)
      KIND_MOVE_X: begin
        st_nxt.pos_x = clamp_x;
      end
      KIND_MOVE_Y: begin
        st_nxt.pos_y = clamp_y;
      end
      KIND_LEFT: begin
        if (sel_mode && level && !st_r.left_level) begin
          st_nxt.start_x  = cur_ix;
          st_nxt.start_y  = cur_iy;
          st_nxt.dragging = 1'b1;
        end else if (sel_mode && !level && st_r.left_level) begin
          st_nxt.end_x    = cur_ix;
          st_nxt.end_y    = cur_iy;
          st_nxt.dragging = 1'b0;
          st_nxt.active   = 1'b1;
        end
        st_nxt.left_level = level;
      end
      KIND_RIGHT: begin
        st_nxt.right_level = level;
        if (sel_mode && level) begin
          st_nxt.active   = 1'b0;
          st_nxt.dragging = 1'b0;
        end
      end
      default: begin
        st_nxt = st_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.pos_x       <= SX_W'(SCREEN_W / 2);
      st_r.pos_y       <= SY_W'(SCREEN_H / 2);
      st_r.left_level  <= 1'b0;
      st_r.right_level <= 1'b0;
      st_r.start_x     <= '0;
      st_r.start_y     <= '0;
      st_r.end_x       <= '0;
      st_r.end_y       <= '0;
      st_r.active      <= 1'b0;
      st_r.dragging    <= 1'b0;
    end else if (en) begin
      st_r <= st_nxt;
    end
  end

  assign st = st_r;

endmodule

// ===== src/pcrs_scale.sv =====
// ----------------------------------------------------------------------------
// Pointer cursor region select result stage
// Scales the cursor to image coordinates and registers the result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcrs_scale import pcrs_pkg::*; (
  input  logic     clk,
  input  logic     load,
  input  state_t   st,
  output out_res_t res
);

  out_res_t res_r;
  out_res_t res_nxt;

  always_comb begin
    res_nxt.screen_x     = st.pos_x;
    res_nxt.screen_y     = st.pos_y;
    res_nxt.image_x      = scale_x(st.pos_x);
    res_nxt.image_y      = scale_y(st.pos_y);
    res_nxt.left_down    = st.left_level;
    res_nxt.right_down   = st.right_level;
    res_nxt.start_x      = st.start_x;
    res_nxt.start_y      = st.start_y;
    res_nxt.end_x        = st.end_x;
    res_nxt.end_y        = st.end_y;
    res_nxt.region_valid = st.active;
    res_nxt.dragging     = st.dragging;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ===== src/pointer_cursor_region_select.sv =====
// ----------------------------------------------------------------------------
// Pointer cursor region select
// Cursor tracking, image scaling and button-driven region selection.
// ----------------------------------------------------------------------------
// Each input beat is one pointer event (motion on X or Y, or a left or right
// button level) on a valid/ready channel. Every event yields exactly one
// result beat with the clamped screen cursor, the cursor in image coordinates,
// the button levels and the selection region status, in event order.
// The event passes an input register, the state update and the result
// register, and one event per cycle is sustained while the receiver takes
// results, since the cursor and selection state are rewritten as each event
// advances. When the receiver stalls, the result beat holds, and events keep
// being taken until the input register and the state stage are also full;
// then in_ready drops. The state stage does not update while its result
// waits. Selection mode is written through cfg_we and cfg_wdata; the user
// must do so only while no event is in flight, which the block does not
// enforce. Synchronous reset puts the cursor at the screen center, clears
// the buttons, region and selection mode and empties the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pointer_cursor_region_select_assert.svh"

module pointer_cursor_region_select import pcrs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_evt_t  in_beat,
  output logic     out_valid,
  input  logic     out_ready,
  output out_res_t out_beat,
  input  logic     cfg_we,
  input  logic     cfg_wdata
);

  logic    sel_mode_r;
  logic    s0_valid_r;
  in_evt_t s0_evt_r;
  logic    s1_valid_r;
  logic    out_valid_r;
  logic    out_take;
  logic    s1_adv;
  logic    s1_free;
  logic    s0_adv;
  logic    in_fire;
  state_t  st;

  assign out_take = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_take;
  assign s1_free  = !s1_valid_r || out_take;
  assign s0_adv   = s0_valid_r && s1_free;
  assign in_ready = !s0_valid_r || s1_free;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_mode_r  <= 1'b0;
      s0_valid_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        sel_mode_r <= cfg_wdata;
      end
      if (in_ready) begin
        s0_valid_r <= in_valid;
      end
      if (s1_free) begin
        s1_valid_r <= s0_adv;
      end
      if (out_take) begin
        out_valid_r <= s1_adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_evt_r <= in_beat;
    end
  end

  pcrs_update u_update (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (s0_adv),
    .sel_mode (sel_mode_r),
    .evt      (s0_evt_r),
    .st       (st)
  );

  pcrs_scale u_scale (
    .clk  (clk),
    .load (s1_adv),
    .st   (st),
    .res  (out_beat)
  );

  assign out_valid = out_valid_r;

  `PCRS_ASSERT_NEXT(a_state_held_on_stall, s1_valid_r && !out_take, $stable(st))
  `PCRS_ASSERT_NOW(a_screen_in_range, out_valid_r, out_beat.screen_x <= SX_W'(SCREEN_W - 1))
  `PCRS_ASSERT_NOW(a_image_in_range, out_valid_r, out_beat.image_x <= IX_W'(IMAGE_W - 1))
  `PCRS_ASSERT_NEXT(a_drain_empties, out_valid_r && out_ready && !s1_valid_r, !out_valid_r)

endmodule

// ===== bench/pointer_cursor_region_select_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pointer cursor region select testbench
// Sends pointer event beats with random gaps against a receiver that stalls
// at random. An in-bench cursor and selection tracker predicts every status
// beat, and each returned beat is compared field by field, in order.
// ----------------------------------------------------------------------------

module pointer_cursor_region_select_tb;
  import pcrs_pkg::*;

  localparam int LONG_HOLD = 60;

  class cursor_scoreboard;
    bit       sel_mode;
    int       cur_x;
    int       cur_y;
    bit       left_lvl;
    bit       right_lvl;
    int       anchor_x;
    int       anchor_y;
    int       corner_x;
    int       corner_y;
    bit       region_held;
    bit       drag_on;
    out_res_t pending_status[$];
    int       errors;
    int       checked;
    int       moves;
    int       buttons;
    int       regions_done;
    int       cancels;

    function new();
      sel_mode = 1'b0;
      cur_x = SCREEN_W / 2;
      cur_y = SCREEN_H / 2;
      left_lvl = 1'b0;
      right_lvl = 1'b0;
      anchor_x = 0;
      anchor_y = 0;
      corner_x = 0;
      corner_y = 0;
      region_held = 1'b0;
      drag_on = 1'b0;
      errors = 0;
      checked = 0;
      moves = 0;
      buttons = 0;
      regions_done = 0;
      cancels = 0;
    endfunction

    function int fit_axis(int s, int size);
      if (s < 0) return 0;
      if (s > size - 1) return size - 1;
      return s;
    endfunction

    function int to_image(int p, int img, int scr);
      int q;
      q = (p * img) / scr;
      return (q > img - 1) ? img - 1 : q;
    endfunction

    function void track_event(in_evt_t ev);
      int       delta;
      bit       lvl;
      int       col;
      int       row;
      out_res_t st;
      delta = $signed(ev.value);
      lvl = (ev.value != '0);
      col = to_image(cur_x, IMAGE_W, SCREEN_W);
      row = to_image(cur_y, IMAGE_H, SCREEN_H);
      case (ev.kind)
        KIND_MOVE_X: begin
          cur_x = fit_axis(cur_x + delta, SCREEN_W);
          moves++;
        end
        KIND_MOVE_Y: begin
          cur_y = fit_axis(cur_y + delta, SCREEN_H);
          moves++;
        end
        KIND_LEFT: begin
          if (sel_mode) begin
            if (lvl && !left_lvl) begin
              anchor_x = col;
              anchor_y = row;
              drag_on = 1'b1;
            end else if (!lvl && left_lvl) begin
              corner_x = col;
              corner_y = row;
              drag_on = 1'b0;
              region_held = 1'b1;
              regions_done++;
            end
          end
          left_lvl = lvl;
          buttons++;
        end
        default: begin
          right_lvl = lvl;
          if (lvl && sel_mode) begin
            region_held = 1'b0;
            drag_on = 1'b0;
            cancels++;
          end
          buttons++;
        end
      endcase
      st.screen_x = SX_W'(cur_x);
      st.screen_y = SY_W'(cur_y);
      st.image_x = IX_W'(to_image(cur_x, IMAGE_W, SCREEN_W));
      st.image_y = IY_W'(to_image(cur_y, IMAGE_H, SCREEN_H));
      st.left_down = left_lvl;
      st.right_down = right_lvl;
      st.start_x = IX_W'(anchor_x);
      st.start_y = IY_W'(anchor_y);
      st.end_x = IX_W'(corner_x);
      st.end_y = IY_W'(corner_y);
      st.region_valid = region_held;
      st.dragging = drag_on;
      pending_status.push_back(st);
    endfunction

    function void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_status(out_res_t got);
      out_res_t want;
      if (pending_status.size() == 0) begin
        $error("status beat arrived with no event outstanding");
        errors++;
        return;
      end
      want = pending_status.pop_front();
      checked++;
      check_field("screen_x", 16'(want.screen_x), 16'(got.screen_x));
      check_field("screen_y", 16'(want.screen_y), 16'(got.screen_y));
      check_field("image_x", 16'(want.image_x), 16'(got.image_x));
      check_field("image_y", 16'(want.image_y), 16'(got.image_y));
      check_field("left_down", 16'(want.left_down), 16'(got.left_down));
      check_field("right_down", 16'(want.right_down), 16'(got.right_down));
      check_field("start_x", 16'(want.start_x), 16'(got.start_x));
      check_field("start_y", 16'(want.start_y), 16'(got.start_y));
      check_field("end_x", 16'(want.end_x), 16'(got.end_x));
      check_field("end_y", 16'(want.end_y), 16'(got.end_y));
      check_field("region_valid", 16'(want.region_valid), 16'(got.region_valid));
      check_field("dragging", 16'(want.dragging), 16'(got.dragging));
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  in_evt_t  in_beat;
  logic     out_valid;
  logic     out_ready;
  out_res_t out_beat;
  logic     cfg_we;
  logic     cfg_wdata;

  cursor_scoreboard board = new();
  bit calm = 1'b0;
  bit long_hold_req = 1'b0;
  int events_sent = 0;
  int mode_writes = 0;

  always #2 clk = ~clk;

  pointer_cursor_region_select DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [VAL_W-1:0] motion_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return VAL_W'(int'($urandom_range(0, 40)) - 20);
    if (r < 80) return VAL_W'(int'($urandom_range(0, 1400)) - 700);
    return VAL_W'($urandom);
  endfunction

  function automatic logic [VAL_W-1:0] pressed_value();
    logic [VAL_W-1:0] v;
    v = VAL_W'($urandom);
    if ($urandom_range(0, 3) == 0 || v == '0) v = VAL_W'(1);
    return v;
  endfunction

  task automatic send_event(kind_t k, logic [VAL_W-1:0] v);
    int      gap;
    in_evt_t ev;
    gap = pick_gap();
    ev.kind = k;
    ev.value = v;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat <= ev;
    do @(posedge clk); while (!in_ready);
    board.track_event(ev);
    events_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending_status.size() != 0);
  endtask

  task automatic write_mode(bit m);
    drain_results();
    repeat (3) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.sel_mode = m;
    mode_writes++;
  endtask

  task automatic run_random(int target);
    int    stop_at;
    int    steps;
    kind_t k;
    stop_at = events_sent + target;
    while (events_sent < stop_at) begin
      if ($urandom_range(0, 99) < 60) begin
        send_event(KIND_LEFT, pressed_value());
        steps = $urandom_range(0, 6);
        repeat (steps) send_event(kind_t'($urandom_range(0, 1)), motion_value());
        if ($urandom_range(0, 5) == 0) send_event(KIND_RIGHT, pressed_value());
        send_event(KIND_LEFT, '0);
        if ($urandom_range(0, 4) == 0) send_event(KIND_RIGHT, '0);
      end else begin
        k = kind_t'($urandom_range(0, 3));
        if (k == KIND_MOVE_X || k == KIND_MOVE_Y) begin
          send_event(k, motion_value());
        end else begin
          send_event(k, ($urandom_range(0, 1) == 0) ? VAL_W'(0) : pressed_value());
        end
      end
      if ($urandom_range(0, 149) == 0) drain_results();
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_status(out_beat);
  end

  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        out_ready <= 1'b0;
        long_hold_req = 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_beat <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Cursor saturation and button levels with selection disabled.
    write_mode(1'b0);
    send_event(KIND_MOVE_X, 16'h7fff);
    send_event(KIND_MOVE_X, 16'h8000);
    send_event(KIND_MOVE_Y, 16'h7fff);
    send_event(KIND_MOVE_Y, 16'h8000);
    send_event(KIND_MOVE_X, 16'd333);
    send_event(KIND_MOVE_Y, 16'd250);
    send_event(KIND_LEFT, 16'h0001);
    send_event(KIND_RIGHT, 16'hffff);
    send_event(KIND_RIGHT, 16'h0000);
    send_event(KIND_LEFT, 16'h0000);
    send_event(KIND_LEFT, 16'h8000);

    // The left button is still down, so the first release latches the end.
    write_mode(1'b1);
    send_event(KIND_LEFT, 16'h0000);
    send_event(KIND_LEFT, 16'h0001);
    send_event(KIND_LEFT, 16'h7fff);
    send_event(KIND_MOVE_X, 16'h7fff);
    send_event(KIND_MOVE_Y, 16'h7fff);
    send_event(KIND_LEFT, 16'h0000);
    send_event(KIND_LEFT, 16'h0000);
    send_event(KIND_RIGHT, 16'h0001);
    send_event(KIND_RIGHT, 16'h0100);
    send_event(KIND_RIGHT, 16'h0000);
    send_event(KIND_MOVE_X, 16'hfffe);
    send_event(KIND_LEFT, 16'h0001);
    send_event(KIND_RIGHT, 16'h0001);
    send_event(KIND_LEFT, 16'h0000);

    for (int p = 0; p < 8; p++) begin
      write_mode(p % 3 != 1);
      calm = (p == 5);
      if (p == 2) begin
        // Hold the receiver off while beats keep coming, so the input stalls.
        calm = 1'b1;
        long_hold_req = 1'b1;
        wait (!long_hold_req);
        repeat (16) send_event(kind_t'($urandom_range(0, 1)), motion_value());
        calm = 1'b0;
        drain_results();
      end
      run_random(230);
    end
    calm = 1'b0;

    drain_results();
    repeat (8) @(posedge clk);
    if (board.pending_status.size() != 0) begin
      $error("%0d status beats never arrived", board.pending_status.size());
    end
    $display("Checked %0d status beats from %0d pointer events (%0d moves, %0d button levels).",
             board.checked, events_sent, board.moves, board.buttons);
    $display("Regions completed: %0d, cancels: %0d, selection mode writes: %0d.",
             board.regions_done, board.cancels, mode_writes);
    if (board.errors == 0 && board.pending_status.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/pcrs_pkg.sv
src/pcrs_update.sv
src/pcrs_scale.sv
src/pointer_cursor_region_select.sv
bench/pointer_cursor_region_select_tb.sv
